/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg - shared types and constants for the I2C register access master
// Item layouts for the tick and result channels, the configuration register
// indexes and their reset values.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT    = 2'd2;

	// Register reset values
	localparam logic [6:0] DEVICE_ADDRESS_RST    = 7'd42;
	localparam logic [7:0] HALF_PERIOD_TICKS_RST = 8'd8;
	localparam logic [7:0] ACK_POLL_LIMIT_RST    = 8'd10;

	// Transaction kinds
	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_READ  = 1'b1;

	// One bus tick in
	typedef struct packed {
		logic        go;
		logic        action;
		logic [7:0]  reg_addr;
		logic [15:0] write_data;
		logic        sda_in;
	} cmd_t;

	// Line levels and status out for one tick
	typedef struct packed {
		logic        scl;
		logic        sda_out;
		logic        sda_drive;
		logic        busy_res;
		logic        done_res;
		logic        nack_error;
		logic [15:0] read_data;
	} res_t;

	// Configuration register contents
	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] half_period_ticks;
		logic [7:0] ack_poll_limit;
	} cfg_t;

endpackage

/* rtl/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// i2cm_seq - bus sequencer of the I2C register access master
// Holds the transaction state and advances it by one bus tick per accepted
// item. Produces the line levels and status for that tick combinationally.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  cmd_t cmd,
	input  cfg_t cfg,
	output res_t res
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_RS0, PH_START1, PH_START2,
		PH_TX_LO, PH_TX_HI, PH_ACK_LO, PH_ACK_HI,
		PH_POLL, PH_RX_LO, PH_RX_HI, PH_MA_LO,
		PH_MA_HI, PH_STOP1, PH_STOP2, PH_STOP3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [2:0]  step_q, step_d;
	logic [7:0]  delay_q, delay_d;
	logic [7:0]  poll_q, poll_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] capt_q, capt_d;
	logic        action_q, action_d;
	logic [7:0]  reg_q, reg_d;
	logic [15:0] wdata_q, wdata_d;
	logic        abort_q, abort_d;

	logic        enter_en;
	phase_t      enter_ph;
	logic        done;
	logic [7:0]  hp_eff;
	logic [2:0]  lines;

	assign hp_eff = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;

	// Next state for one tick
	always_comb begin
		phase_d  = phase_q;
		bit_d    = bit_q;
		step_d   = step_q;
		delay_d  = delay_q;
		poll_d   = poll_q;
		shift_d  = shift_q;
		capt_d   = capt_q;
		action_d = action_q;
		reg_d    = reg_q;
		wdata_d  = wdata_q;
		abort_d  = abort_q;
		enter_en = 1'b0;
		enter_ph = PH_IDLE;
		done     = 1'b0;

		priority if (phase_q == PH_IDLE) begin
			// Latch the command and open with START
			if (cmd.go) begin
				action_d = cmd.action;
				reg_d    = cmd.reg_addr;
				wdata_d  = cmd.write_data;
				capt_d   = 16'd0;
				abort_d  = 1'b0;
				step_d   = 3'd0;
				enter_en = 1'b1;
				enter_ph = PH_START1;
			end
		end else if (phase_q == PH_POLL) begin
			priority if (!cmd.sda_in) begin
				// Byte acknowledged: pick the next byte or segment
				step_d   = step_q + 3'd1;
				enter_en = 1'b1;
				priority if (step_d == 3'd1) begin
					shift_d  = reg_q;
					bit_d    = 4'd0;
					enter_ph = PH_TX_LO;
				end else if (action_q == ACTION_WRITE) begin
					priority if (step_d == 3'd2) begin
						shift_d  = wdata_q[15:8];
						bit_d    = 4'd0;
						enter_ph = PH_TX_LO;
					end else if (step_d == 3'd3) begin
						shift_d  = wdata_q[7:0];
						bit_d    = 4'd0;
						enter_ph = PH_TX_LO;
					end else begin
						enter_ph = PH_STOP1;
					end
				end else if (step_d == 3'd2) begin
					enter_ph = PH_RS0;
				end else begin
					shift_d  = 8'd0;
					bit_d    = 4'd0;
					enter_ph = PH_RX_LO;
				end
			end else if (poll_q >= cfg.ack_poll_limit) begin
				// Out of polls: abort through STOP
				abort_d  = 1'b1;
				enter_en = 1'b1;
				enter_ph = PH_STOP1;
			end else begin
				poll_d = poll_q + 8'd1;
			end
		end else if (delay_q > 8'd1) begin
			delay_d = delay_q - 8'd1;
		end else begin
			// Segment elapsed: move to the next one
			unique case (phase_q)
				PH_RS0: begin
					enter_en = 1'b1;
					enter_ph = PH_START1;
				end
				PH_START1: begin
					enter_en = 1'b1;
					enter_ph = PH_START2;
				end
				PH_START2: begin
					shift_d  = {cfg.device_address, (step_q == 3'd2)};
					bit_d    = 4'd0;
					enter_en = 1'b1;
					enter_ph = PH_TX_LO;
				end
				PH_TX_LO: begin
					enter_en = 1'b1;
					enter_ph = PH_TX_HI;
				end
				PH_TX_HI: begin
					shift_d  = {shift_q[6:0], 1'b0};
					bit_d    = bit_q + 4'd1;
					enter_en = 1'b1;
					enter_ph = (bit_d >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
				end
				PH_ACK_LO: begin
					enter_en = 1'b1;
					enter_ph = PH_ACK_HI;
				end
				PH_ACK_HI: begin
					enter_en = 1'b1;
					enter_ph = PH_POLL;
				end
				PH_RX_LO: begin
					enter_en = 1'b1;
					enter_ph = PH_RX_HI;
				end
				PH_RX_HI: begin
					shift_d  = {shift_q[6:0], cmd.sda_in};
					bit_d    = bit_q + 4'd1;
					enter_en = 1'b1;
					if (bit_d >= 4'd8) begin
						if (step_q == 3'd3) begin
							capt_d = {shift_d, capt_q[7:0]};
						end else begin
							capt_d = {capt_q[15:8], shift_d};
						end
						enter_ph = PH_MA_LO;
					end else begin
						enter_ph = PH_RX_LO;
					end
				end
				PH_MA_LO: begin
					enter_en = 1'b1;
					enter_ph = PH_MA_HI;
				end
				PH_MA_HI: begin
					enter_en = 1'b1;
					if (step_q == 3'd3) begin
						step_d   = 3'd4;
						shift_d  = 8'd0;
						bit_d    = 4'd0;
						enter_ph = PH_RX_LO;
					end else begin
						enter_ph = PH_STOP1;
					end
				end
				PH_STOP1: begin
					enter_en = 1'b1;
					enter_ph = PH_STOP2;
				end
				PH_STOP2: begin
					enter_en = 1'b1;
					enter_ph = PH_STOP3;
				end
				PH_STOP3: begin
					phase_d = PH_IDLE;
					delay_d = 8'd0;
					done    = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
					delay_d = 8'd0;
				end
			endcase
		end

		// Enter a new segment: reload the delay, clear polls on ACK wait
		if (enter_en) begin
			phase_d = enter_ph;
			delay_d = hp_eff;
			if (enter_ph == PH_POLL) begin
				poll_d = 8'd0;
			end
		end
	end

	// Line levels of the segment after this tick: {scl, sda, drive}
	always_comb begin
		unique case (phase_d)
			PH_RS0:                       lines = 3'b011;
			PH_START2:                    lines = 3'b101;
			PH_TX_LO:                     lines = {1'b0, shift_d[7], 1'b1};
			PH_TX_HI:                     lines = {1'b1, shift_d[7], 1'b1};
			PH_ACK_LO, PH_RX_LO:          lines = 3'b010;
			PH_ACK_HI, PH_POLL, PH_RX_HI: lines = 3'b110;
			PH_MA_LO:                     lines = {1'b0, (step_d == 3'd4), 1'b1};
			PH_MA_HI:                     lines = {1'b1, (step_d == 3'd4), 1'b1};
			PH_STOP1:                     lines = 3'b001;
			PH_STOP2:                     lines = 3'b101;
			default:                      lines = 3'b111;
		endcase
	end

	// Result for this tick
	always_comb begin
		res.scl        = lines[2];
		res.sda_out    = lines[1];
		res.sda_drive  = lines[0];
		res.busy_res   = (phase_d != PH_IDLE);
		res.done_res   = done;
		res.nack_error = done && abort_d;
		res.read_data  = (done && !abort_d && (action_d == ACTION_READ)) ? capt_d : 16'd0;
	end

	// Hold state; advance on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= 4'd0;
			step_q   <= 3'd0;
			delay_q  <= 8'd0;
			poll_q   <= 8'd0;
			shift_q  <= 8'd0;
			capt_q   <= 16'd0;
			action_q <= 1'b0;
			reg_q    <= 8'd0;
			wdata_q  <= 16'd0;
			abort_q  <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_d;
			bit_q    <= bit_d;
			step_q   <= step_d;
			delay_q  <= delay_d;
			poll_q   <= poll_d;
			shift_q  <= shift_d;
			capt_q   <= capt_d;
			action_q <= action_d;
			reg_q    <= reg_d;
			wdata_q  <= wdata_d;
			abort_q  <= abort_d;
		end
	end

endmodule

/* rtl/i2c_register_access_master_core.sv */
// ----------------------------------------------------------------------------
// i2c_register_access_master_core - I2C master for 16-bit register access
// Runs one register write or read per command, one bus tick per item, and
// reports line levels, status and read data for every tick.
//
//   channel | direction | handshake                 | item
//   --------+-----------+---------------------------+--------------------
//   cmd     | in        | cmd_valid / cmd_stall     | cmd_t (one tick)
//   res     | out       | res_valid / res_stall     | res_t (one per tick)
//   cfg     | in        | cfg_we, cfg_index         | cfg_data (8 bits)
//
// One item per clock cycle while cmd_stall is low; its result sits in the output
// register in the cycle after acceptance. The sequencer state advances only on an
// accepted item. cmd_stall rises only while the output register holds an untaken
// result and res_stall is high. Reset clears the sequencer to idle, empties
// the output register and loads the register reset values.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core import i2cm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  cmd_t                   cmd,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_t                   res,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	res_t step_res;
	res_t res_q;
	logic res_valid_q;
	logic accept;

	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= DEVICE_ADDRESS_RST;
			cfg_q.half_period_ticks <= HALF_PERIOD_TICKS_RST;
			cfg_q.ack_poll_limit    <= ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS:    cfg_q.device_address    <= cfg_data[6:0];
				CFG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_data;
				CFG_ACK_POLL_LIMIT:    cfg_q.ack_poll_limit    <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (accept),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.res    (step_res)
	);

	// Output register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/i2cm_checker.sv */
// ----------------------------------------------------------------------------
// i2cm_checker - port-level checks for the I2C register access master
// Watches the top-level ports and flags status and flow-control slips.
// ----------------------------------------------------------------------------
module i2cm_checker import i2cm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// The ending tick leaves the bus idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> !res.busy_res)
		else $error("done_res with busy_res set");

	// An error is only reported with done
	a_nack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.nack_error |-> res.done_res)
		else $error("nack_error without done_res");

	// Read data is zero except on the ending tick
	a_data_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.done_res |-> res.read_data == 16'd0)
		else $error("read_data nonzero outside done");

	// A held result blocks the next tick
	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> cmd_stall)
		else $error("cmd accepted while result held");

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

endmodule

bind i2c_register_access_master_core i2cm_checker u_i2cm_checker (.*);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - I2C register access master, per-tick bus level check
// Drives one bus tick per item while a behavioral slave answers ACK polls and
// read bits. A bus model in the scoreboard predicts line levels, status and
// read data for every accepted tick. Every result is compared field by field.
// ----------------------------------------------------------------------------
import i2cm_pkg::*;

typedef enum logic [4:0] {
	ST_IDLE, ST_RESTART, ST_START_A, ST_START_B, ST_BIT_LO, ST_BIT_HI,
	ST_ACK_LO, ST_ACK_HI, ST_ACK_POLL, ST_RX_LO, ST_RX_HI, ST_MACK_LO,
	ST_MACK_HI, ST_STOP_A, ST_STOP_B, ST_STOP_C
} bus_phase_e;

class bus_level_model;
	// Register copies
	logic [6:0]  dev_addr;
	logic [7:0]  half_ticks;
	logic [7:0]  poll_limit;
	// Sequencer copy
	bus_phase_e  phase;
	logic [3:0]  bit_cnt;
	logic [2:0]  byte_idx;
	logic [7:0]  delay;
	logic [7:0]  polls;
	logic [7:0]  shreg;
	logic [15:0] rx_word;
	logic        rd_cmd;
	logic [7:0]  reg_byte;
	logic [15:0] wr_word;
	logic        aborted;
	// Outcomes of accepted ticks not yet seen at the output
	res_t        due_ticks[$];
	int unsigned mismatches;
	int unsigned seen;

	function new();
		dev_addr = DEVICE_ADDRESS_RST;
		half_ticks = HALF_PERIOD_TICKS_RST;
		poll_limit = ACK_POLL_LIMIT_RST;
		phase = ST_IDLE;
		bit_cnt = '0;
		byte_idx = '0;
		delay = '0;
		polls = '0;
		shreg = '0;
		rx_word = '0;
		rd_cmd = 1'b0;
		reg_byte = '0;
		wr_word = '0;
		aborted = 1'b0;
		mismatches = 0;
		seen = 0;
	endfunction

	function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_DEVICE_ADDRESS: dev_addr = v[6:0];
			CFG_HALF_PERIOD_TICKS: half_ticks = v;
			CFG_ACK_POLL_LIMIT: poll_limit = v;
			default: ;
		endcase
	endfunction

	// Enter a timed segment; a zero half period counts as one tick
	function void go_to(bus_phase_e p);
		phase = p;
		delay = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
		if (p == ST_ACK_POLL)
			polls = 8'd0;
	endfunction

	function void load_byte(logic [7:0] b);
		shreg = b;
		bit_cnt = 4'd0;
		go_to(ST_BIT_LO);
	endfunction

	// Advance to the next byte of the transaction after a slave ACK
	function void byte_acked();
		byte_idx = byte_idx + 3'd1;
		if (byte_idx == 3'd1) begin
			load_byte(reg_byte);
		end else if (!rd_cmd) begin
			if (byte_idx == 3'd2)
				load_byte(wr_word[15:8]);
			else if (byte_idx == 3'd3)
				load_byte(wr_word[7:0]);
			else
				go_to(ST_STOP_A);
		end else if (byte_idx == 3'd2) begin
			go_to(ST_RESTART);
		end else begin
			shreg = 8'd0;
			bit_cnt = 4'd0;
			go_to(ST_RX_LO);
		end
	endfunction

	// {scl, sda_out, sda_drive} for the current segment
	function logic [2:0] line_levels();
		case (phase)
			ST_RESTART: return 3'b011;
			ST_START_B: return 3'b101;
			ST_BIT_LO: return {1'b0, shreg[7], 1'b1};
			ST_BIT_HI: return {1'b1, shreg[7], 1'b1};
			ST_ACK_LO, ST_RX_LO: return 3'b010;
			ST_ACK_HI, ST_ACK_POLL, ST_RX_HI: return 3'b110;
			ST_MACK_LO: return {1'b0, byte_idx == 3'd4, 1'b1};
			ST_MACK_HI: return {1'b1, byte_idx == 3'd4, 1'b1};
			ST_STOP_A: return 3'b001;
			ST_STOP_B: return 3'b101;
			default: return 3'b111;
		endcase
	endfunction

	// Advance the bus by one accepted tick and queue its outcome
	function void note_tick(cmd_t t);
		res_t r;
		logic [2:0] lv;
		logic done;
		done = 1'b0;
		if (phase == ST_IDLE) begin
			if (t.go) begin
				rd_cmd = t.action;
				reg_byte = t.reg_addr;
				wr_word = t.write_data;
				rx_word = 16'd0;
				aborted = 1'b0;
				byte_idx = 3'd0;
				go_to(ST_START_A);
			end
		end else if (phase == ST_ACK_POLL) begin
			if (!t.sda_in) begin
				byte_acked();
			end else if (polls >= poll_limit) begin
				aborted = 1'b1;
				go_to(ST_STOP_A);
			end else begin
				polls = polls + 8'd1;
			end
		end else if (delay > 8'd1) begin
			delay = delay - 8'd1;
		end else begin
			case (phase)
				ST_RESTART: go_to(ST_START_A);
				ST_START_A: go_to(ST_START_B);
				ST_START_B: load_byte({dev_addr, byte_idx == 3'd2});
				ST_BIT_LO: go_to(ST_BIT_HI);
				ST_BIT_HI: begin
					shreg = {shreg[6:0], 1'b0};
					bit_cnt = bit_cnt + 4'd1;
					go_to(bit_cnt >= 4'd8 ? ST_ACK_LO : ST_BIT_LO);
				end
				ST_ACK_LO: go_to(ST_ACK_HI);
				ST_ACK_HI: go_to(ST_ACK_POLL);
				ST_RX_LO: go_to(ST_RX_HI);
				ST_RX_HI: begin
					shreg = {shreg[6:0], t.sda_in};
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= 4'd8) begin
						if (byte_idx == 3'd3)
							rx_word[15:8] = shreg;
						else
							rx_word[7:0] = shreg;
						go_to(ST_MACK_LO);
					end else begin
						go_to(ST_RX_LO);
					end
				end
				ST_MACK_LO: go_to(ST_MACK_HI);
				ST_MACK_HI: begin
					if (byte_idx == 3'd3) begin
						byte_idx = 3'd4;
						shreg = 8'd0;
						bit_cnt = 4'd0;
						go_to(ST_RX_LO);
					end else begin
						go_to(ST_STOP_A);
					end
				end
				ST_STOP_A: go_to(ST_STOP_B);
				ST_STOP_B: go_to(ST_STOP_C);
				ST_STOP_C: begin
					phase = ST_IDLE;
					delay = 8'd0;
					done = 1'b1;
				end
				default: begin
					phase = ST_IDLE;
					delay = 8'd0;
				end
			endcase
		end
		lv = line_levels();
		r.scl = lv[2];
		r.sda_out = lv[1];
		r.sda_drive = lv[0];
		r.busy_res = (phase != ST_IDLE);
		r.done_res = done;
		r.nack_error = done && aborted;
		r.read_data = (done && !aborted && rd_cmd) ? rx_word : 16'd0;
		due_ticks.push_back(r);
	endfunction

	task report(string msg);
		if (mismatches < 200)
			$display("MISMATCH tick %0d: %s", seen, msg);
		mismatches++;
	endtask

	task compare(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Check one result against the oldest outcome due
	task check_tick(res_t got);
		res_t want;
		seen++;
		if (due_ticks.size() == 0) begin
			report("result with no tick due");
		end else begin
			want = due_ticks.pop_front();
			compare("scl", 16'(got.scl), 16'(want.scl));
			compare("sda_out", 16'(got.sda_out), 16'(want.sda_out));
			compare("sda_drive", 16'(got.sda_drive), 16'(want.sda_drive));
			compare("busy_res", 16'(got.busy_res), 16'(want.busy_res));
			compare("done_res", 16'(got.done_res), 16'(want.done_res));
			compare("nack_error", 16'(got.nack_error), 16'(want.nack_error));
			compare("read_data", got.read_data, want.read_data);
		end
	endtask
endclass

module testbench;

	localparam int NO_TICK_CAP = 32'h7fffffff;
	localparam int STALL_LIMIT = 1000;
	localparam int unsigned TICK_TOTAL = 1950;
	localparam int unsigned CALM_FROM  = 1800;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cmd_valid;
	logic                   cmd_stall;
	cmd_t                   cmd;
	logic                   res_valid;
	logic                   res_stall;
	res_t                   res;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bus_level_model tracker;

	// Slave behavior for the transfer in progress
	int          fail_byte;
	int          ack_wait;
	logic [15:0] slave_word;
	bit          chatter;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned tick_count = 0;
	int unsigned stall_cycles = 0;

	i2c_register_access_master_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Build the next tick: random fields, slave answers where the bus samples
	function automatic cmd_t next_tick();
		cmd_t t;
		logic [31:0] r;
		int idx;
		r = $urandom;
		t = r[$bits(cmd_t)-1:0];
		if (!chatter) begin
			if (tracker.phase == ST_ACK_POLL) begin
				if (int'(tracker.byte_idx) == fail_byte)
					t.sda_in = 1'b1;
				else
					t.sda_in = (int'(tracker.polls) >= ack_wait) ? 1'b0 : 1'b1;
			end else if (tracker.phase == ST_RX_HI && tracker.delay == 8'd1) begin
				idx = (tracker.byte_idx == 3'd3) ? 15 - int'(tracker.bit_cnt)
					: 7 - int'(tracker.bit_cnt);
				t.sda_in = slave_word[idx];
			end
		end
		return t;
	endfunction

	// Offer one tick, with an occasional gap first, and hold until taken
	task drive_tick(input cmd_t t);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd <= t;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		tracker.note_tick(t);
		tick_count++;
	endtask

	// Hold off the sender until every outcome due has come back
	task drain();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.due_ticks.size() != 0);
	endtask

	task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, v);
		@(posedge clk);
	endtask

	task advance_transfer(input int max_ticks);
		int n;
		n = 0;
		while (tracker.phase != ST_IDLE && n < max_ticks) begin
			drive_tick(next_tick());
			n++;
		end
	endtask

	// Start a transaction from idle with a go tick, then run it for up to max_ticks more ticks
	task run_transfer(input logic act, input logic [7:0] ra, input logic [15:0] wd,
			input int fail_at, input int wait_polls, input logic [15:0] word,
			input bit noisy, input int max_ticks);
		cmd_t t;
		fail_byte = fail_at;
		ack_wait = wait_polls;
		slave_word = word;
		chatter = noisy;
		t = next_tick();
		t.go = 1'b1;
		t.action = act;
		t.reg_addr = ra;
		t.write_data = wd;
		drive_tick(t);
		advance_transfer(max_ticks);
	endtask

	function automatic int pick_ack_wait();
		int lim;
		int pick;
		lim = int'(tracker.poll_limit);
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return 0;
		else if (pick < 9)
			return $urandom_range(0, (lim < 4) ? lim : 4);
		return lim;
	endfunction

	// Drain, then move to a fresh bus setting and idling mix
	task retune(input bit calm);
		int pick;
		drain();
		if ($urandom_range(0, 1) != 0)
			write_reg(CFG_DEVICE_ADDRESS, 8'($urandom_range(0, 127)));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			write_reg(CFG_HALF_PERIOD_TICKS, 8'd0);
		else if (pick < 6)
			write_reg(CFG_HALF_PERIOD_TICKS, 8'd1);
		else if (pick < 8)
			write_reg(CFG_HALF_PERIOD_TICKS, 8'd2);
		else if (pick == 8)
			write_reg(CFG_HALF_PERIOD_TICKS, 8'd3);
		else
			write_reg(CFG_HALF_PERIOD_TICKS, 8'($urandom_range(4, 6)));
		pick = $urandom_range(0, 9);
		if (pick < 5)
			write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(0, 3)));
		else if (pick < 8)
			write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(4, 20)));
		else if (pick == 8)
			write_reg(CFG_ACK_POLL_LIMIT, 8'd255);
		else
			write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(0, 255)));
		if (calm) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end else begin
			pick = $urandom_range(0, 2);
			tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
			pick = $urandom_range(0, 2);
			rx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
		end
	endtask

	// Receiver: stall in random bursts
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Check every result taken
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_tick(res);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int xfers;
		int k;
		bit calm;
		cmd_t t;
		tracker = new();
		fail_byte = -1;
		ack_wait = 0;
		slave_word = '0;
		chatter = 1'b0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, extremes, NACK on each kind of byte
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		run_transfer(ACTION_WRITE, 8'h5A, 16'hA55A, 0, 0, 16'h0000, 1'b0, NO_TICK_CAP);
		drain();
		write_reg(CFG_HALF_PERIOD_TICKS, 8'd1);
		write_reg(CFG_ACK_POLL_LIMIT, 8'd0);
		write_reg(CFG_DEVICE_ADDRESS, 8'd127);
		run_transfer(ACTION_WRITE, 8'hFF, 16'hFFFF, -1, 0, 16'h0000, 1'b0, NO_TICK_CAP);
		run_transfer(ACTION_READ, 8'h00, 16'h0000, -1, 0, 16'hFFFF, 1'b0, NO_TICK_CAP);
		drain();
		write_reg(CFG_DEVICE_ADDRESS, 8'd0);
		write_reg(CFG_HALF_PERIOD_TICKS, 8'd0);
		run_transfer(ACTION_WRITE, 8'h00, 16'h0000, -1, 0, 16'h0000, 1'b0, NO_TICK_CAP);
		run_transfer(ACTION_READ, 8'h81, 16'hFFFF, -1, 0, 16'h8001, 1'b0, NO_TICK_CAP);
		run_transfer(ACTION_WRITE, 8'h3C, 16'h1234, 0, 0, 16'h0000, 1'b0, NO_TICK_CAP);
		drain();
		write_reg(CFG_ACK_POLL_LIMIT, 8'd3);
		run_transfer(ACTION_READ, 8'h7E, 16'h0000, 2, 0, 16'h0000, 1'b0, NO_TICK_CAP);
		run_transfer(ACTION_WRITE, 8'hC3, 16'hBEEF, 3, 1, 16'h0000, 1'b0, NO_TICK_CAP);
		run_transfer(ACTION_WRITE, 8'h11, 16'h8000, -1, 3, 16'h0000, 1'b0, NO_TICK_CAP);
		run_transfer(ACTION_READ, 8'h22, 16'h0000, -1, 3, 16'h5AA5, 1'b0, NO_TICK_CAP);

		// Slowest bus, then retime and widen the poll window mid-transfer
		drain();
		write_reg(CFG_HALF_PERIOD_TICKS, 8'd255);
		run_transfer(ACTION_WRITE, 8'h99, 16'h0101, 1, 0, 16'h0000, 1'b0, 254);
		drain();
		write_reg(CFG_HALF_PERIOD_TICKS, 8'd1);
		write_reg(CFG_ACK_POLL_LIMIT, 8'd255);
		advance_transfer(NO_TICK_CAP);

		// Random transfers, mostly well formed, some NACKs and line noise
		xfers = 0;
		while (tick_count < TICK_TOTAL) begin
			calm = (tick_count >= CALM_FROM);
			if (xfers % 4 == 0)
				retune(calm);
			if (calm) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			k = $urandom_range(0, 2);
			repeat (k) begin
				t = next_tick();
				t.go = 1'b0;
				drive_tick(t);
			end
			run_transfer(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
				($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 3)) : -1,
				pick_ack_wait(), 16'($urandom), ($urandom_range(0, 11) == 0),
				NO_TICK_CAP);
			xfers++;
		end

		// Wait out the last results
		drain();
		repeat (4) @(posedge clk);
		if (tracker.due_ticks.size() != 0)
			tracker.report($sformatf("%0d ticks never answered", tracker.due_ticks.size()));
		if (tracker.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
